// ===== hw/rtl/ufe_pkg.sv =====
`timescale 1ns / 1ps

package ufe_pkg;

   // element index width, fixed by the word format
   localparam int ELEM_W = 10;

   // default table depth
   localparam int ELEMENT_COUNT_DEF = 1024;

   // depth of the command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // opcodes
   localparam logic OP_FIND  = 1'b0;
   localparam logic OP_UNITE = 1'b1;

   typedef logic [ELEM_W-1:0] elem_type;

   // request word
   typedef struct packed {
      logic     opcode;
      elem_type first_element;
      elem_type second_element;
   } req_type;

   // response word
   typedef struct packed {
      elem_type root_index;
      logic     already_joined;
   } rsp_type;

   // classified command as it sits in the queue
   typedef struct packed {
      logic     unite;   // unite, else find
      logic     same;    // unite of an element with itself
      logic     a_in;    // first element has a table entry
      logic     b_in;    // second element has a table entry
      elem_type elem_a;
      elem_type elem_b;
   } cmd_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_COMPRESS,
      ST_DONE
   } back_state_type;

   // true when an element index has a parent table entry
   function automatic logic in_table(elem_type e, int count);
      return 32'(e) < 32'(count);
   endfunction

endpackage

// ===== hw/rtl/union_find_engine.sv =====
`timescale 1ns / 1ps

// Disjoint-set engine with path compression over a parent table.
// Request channel: a word (opcode, first_element, second_element) is taken
// at a rising edge where start is high and busy is low. Find returns the
// root of first_element; unite finds both roots, links the first under the
// second if they differ and both have entries, and returns it with already_joined.
// Response channel: each word appears on rsp_word for exactly one cycle with
// rsp_strobe high; the receiver cannot stall it, so there is no back-pressure.
// A two-deep command queue lets requests be taken while the back end works;
// busy rises when the queue is full.
// Steps of a find with the back end idle, from the accepting edge: a pop
// from the queue, walk reads along the path to the root, compress writes
// that point each node on the path at the root, forming the word, and the
// output register. Finding a root directly needs no compress writes; an
// element with no table entry needs no walk. A unite runs a find on each
// element in turn; a unite of an element with itself costs one find. The
// back end runs one word at a time and takes the next only from idle.
// Reset: the table is rewritten so every entry holds its own index, one entry
// a cycle; busy stays high after reset drops until the last entry is written.
module union_find_engine
   import ufe_pkg::*;
#(
   parameter int ELEMENT_COUNT = ELEMENT_COUNT_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_word,
   output logic    rsp_strobe,
   output rsp_type rsp_word
);

   queue_head_type head;
   logic           q_full;
   logic           q_pop;
   logic           clearing;
   logic           accept;

   // take a word only when the queue has room and the table is ready
   assign busy   = q_full || clearing;
   assign accept = start && !busy;

   ufe_front #(
      .ELEMENT_COUNT(ELEMENT_COUNT)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (accept),
      .req_word(req_word),
      .pop     (q_pop),
      .head    (head),
      .full    (q_full)
   );

   ufe_back #(
      .ELEMENT_COUNT(ELEMENT_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (q_pop),
      .clearing  (clearing),
      .rsp_strobe(rsp_strobe),
      .rsp_word  (rsp_word)
   );

   // table clear starts right after reset
   a_clear_after_reset: assert property (
      @(posedge clock) disable iff (reset) $fell(reset) |-> busy
   ) else $error("busy low right after reset");

   // no response while the table is being cleared
   a_no_rsp_in_clear: assert property (
      @(posedge clock) disable iff (reset) clearing |-> !rsp_strobe
   ) else $error("response during table clear");

   // back end never pops an empty queue
   a_pop_valid: assert property (
      @(posedge clock) disable iff (reset) q_pop |-> head.valid
   ) else $error("pop from empty queue");

   // every command passes through idle before its response, so strobes never abut
   a_strobe_gap: assert property (
      @(posedge clock) disable iff (reset) rsp_strobe |=> !rsp_strobe
   ) else $error("back-to-back response strobes");

endmodule

// ===== hw/rtl/ufe_front.sv =====
`timescale 1ns / 1ps

module ufe_front
   import ufe_pkg::*;
#(
   parameter int ELEMENT_COUNT = ELEMENT_COUNT_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  req_type        req_word,
   input  logic           pop,
   output queue_head_type head,
   output logic           full
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cmd_type        cmd;
   cmd_type        q_ff [QUEUE_DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;

   // classify the incoming word
   always_comb begin
      cmd.unite  = (req_word.opcode == OP_UNITE);
      cmd.same   = (req_word.opcode == OP_UNITE) &&
                   (req_word.first_element == req_word.second_element);
      cmd.a_in   = in_table(req_word.first_element, ELEMENT_COUNT);
      cmd.b_in   = in_table(req_word.second_element, ELEMENT_COUNT);
      cmd.elem_a = req_word.first_element;
      cmd.elem_b = req_word.second_element;
   end

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.cmd   = q_ff[rd_ptr_ff];
   assign full       = (count_ff == CW'(QUEUE_DEPTH));

endmodule

// ===== hw/rtl/ufe_back.sv =====
`timescale 1ns / 1ps

module ufe_back
   import ufe_pkg::*;
#(
   parameter int ELEMENT_COUNT = ELEMENT_COUNT_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type head,
   output logic           pop,
   output logic           clearing,
   output logic           rsp_strobe,
   output rsp_type        rsp_word
);

   localparam int AW = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1;
   localparam int WW = (AW > ELEM_W) ? AW : ELEM_W;

   // element index to table address
   function automatic logic [AW-1:0] to_addr(elem_type e);
      logic [WW-1:0] w;
      w = WW'(e);
      return w[AW-1:0];
   endfunction

   back_state_type state_ff, state_in;
   logic [AW-1:0]  clr_ff, clr_in;
   cmd_type        cmd_ff, cmd_in;
   logic           phase_b_ff, phase_b_in;
   elem_type       tgt_ff, tgt_in;
   elem_type       walk_ff, walk_in;
   elem_type       root_ff, root_in;
   elem_type       ra_ff, ra_in;
   logic           rsp_strobe_ff, rsp_strobe_in;
   rsp_type        rsp_ff, rsp_in;

   // parent table port signals
   elem_type       parent_mem [ELEMENT_COUNT];
   logic           rd_en;
   logic [AW-1:0]  rd_addr;
   elem_type       rd_data_ff;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   elem_type       wr_data;
   logic [WW-1:0]  clr_wide;

   assign clr_wide = WW'(clr_ff);

   // next state and memory control
   always_comb begin
      logic     launch;
      logic     launch_in;
      elem_type launch_e;
      elem_type p;

      state_in      = state_ff;
      clr_in        = clr_ff;
      cmd_in        = cmd_ff;
      phase_b_in    = phase_b_ff;
      tgt_in        = tgt_ff;
      walk_in       = walk_ff;
      root_in       = root_ff;
      ra_in         = ra_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      pop           = 1'b0;
      launch        = 1'b0;
      launch_in     = 1'b0;
      launch_e      = '0;
      p             = rd_data_ff;

      case (state_ff)
         // write every entry with its own index
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = clr_wide[ELEM_W-1:0];
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == AW'(ELEMENT_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end

         // take the next command and start on its first element
         ST_IDLE: begin
            if (head.valid) begin
               pop        = 1'b1;
               cmd_in     = head.cmd;
               phase_b_in = 1'b0;
               launch     = 1'b1;
               launch_e   = head.cmd.elem_a;
               launch_in  = head.cmd.a_in;
            end
         end

         // follow parent links up to the root
         ST_WALK: begin
            if (p == walk_ff || !in_table(p, ELEMENT_COUNT)) begin
               root_in = p;
               if (tgt_ff == p) begin
                  state_in = ST_DONE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = to_addr(tgt_ff);
                  walk_in  = tgt_ff;
                  state_in = ST_COMPRESS;
               end
            end else begin
               walk_in = p;
               rd_en   = 1'b1;
               rd_addr = to_addr(p);
            end
         end

         // walk the path again, pointing each node at the root
         ST_COMPRESS: begin
            wr_en   = 1'b1;
            wr_addr = to_addr(walk_ff);
            wr_data = root_ff;
            if (p == root_ff || !in_table(p, ELEMENT_COUNT)) begin
               state_in = ST_DONE;
            end else begin
               walk_in = p;
               rd_en   = 1'b1;
               rd_addr = to_addr(p);
            end
         end

         // second find, or link and respond
         ST_DONE: begin
            if (cmd_ff.unite && !cmd_ff.same && !phase_b_ff) begin
               ra_in      = root_ff;
               phase_b_in = 1'b1;
               launch     = 1'b1;
               launch_e   = cmd_ff.elem_b;
               launch_in  = cmd_ff.b_in;
            end else begin
               rsp_strobe_in      = 1'b1;
               rsp_in.root_index  = root_ff;
               rsp_in.already_joined = 1'b0;
               if (cmd_ff.same) begin
                  rsp_in.already_joined = 1'b1;
               end else if (phase_b_ff) begin
                  rsp_in.already_joined = (ra_ff == root_ff);
                  if (ra_ff != root_ff && cmd_ff.a_in && cmd_ff.b_in) begin
                     wr_en   = 1'b1;
                     wr_addr = to_addr(ra_ff);
                     wr_data = root_ff;
                  end
               end
               phase_b_in = 1'b0;
               state_in   = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // begin a find: elements without an entry are their own root
      if (launch) begin
         tgt_in = launch_e;
         if (launch_in) begin
            rd_en    = 1'b1;
            rd_addr  = to_addr(launch_e);
            walk_in  = launch_e;
            state_in = ST_WALK;
         end else begin
            root_in  = launch_e;
            state_in = ST_DONE;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         phase_b_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         phase_b_ff    <= phase_b_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      tgt_ff  <= tgt_in;
      walk_ff <= walk_in;
      root_ff <= root_in;
      ra_ff   <= ra_in;
      rsp_ff  <= rsp_in;
   end

   // parent table, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         parent_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= parent_mem[rd_addr];
      end
   end

   assign clearing   = (state_ff == ST_CLEAR);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

// ===== bench/tb_union_find_engine.sv =====
`timescale 1ns / 1ps

module tb_union_find_engine;
   import ufe_pkg::*;

   localparam int TABLE_DEPTH   = ELEMENT_COUNT_DEF;
   localparam int TOP_ELEM      = TABLE_DEPTH - 1;
   localparam int RANDOM_ITEMS  = 1500;
   localparam int CALM_WORDS    = 150;     // last words go out with no gaps
   localparam int DRAIN_CYCLES  = 64;
   localparam int STALL_LIMIT   = 60000;   // clear pass plus a worst-case walk, several times

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_word = '0;
   logic    rsp_strobe;
   rsp_type rsp_word;

   union_find_engine dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   req_type  words_waiting[$];   // words not yet offered to the block
   rsp_type  answers_due[$];     // predicted responses, oldest first
   elem_type links [TABLE_DEPTH]; // predicted parent table
   int       mismatch_count = 0;
   int       stall_cycles   = 0;
   logic     word_taken     = 1'b0;
   int       gap_left       = 0;
   int       stretch_left   = 0;
   logic     gaps_on        = 1'b0;

   task automatic flag_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   function automatic logic has_entry(elem_type e);
      return int'(e) < TABLE_DEPTH;
   endfunction

   // walk to the root, then point every node on the path at it
   function automatic elem_type settle_root(elem_type e);
      elem_type top;
      elem_type walk;
      elem_type hop;
      int       steps;
      if (!has_entry(e))
         return e;
      top   = e;
      steps = 0;
      while (steps < TABLE_DEPTH) begin
         hop = links[top];
         if (hop == top || !has_entry(hop)) begin
            top = hop;
            break;
         end
         top = hop;
         steps++;
      end
      walk  = e;
      steps = 0;
      while (walk != top && has_entry(walk) && steps < TABLE_DEPTH) begin
         hop         = links[walk];
         links[walk] = top;
         walk        = hop;
         steps++;
      end
      return top;
   endfunction

   // expected response for one request word; updates the predicted table
   function automatic rsp_type predict_answer(req_type w);
      rsp_type  ans;
      elem_type ra;
      elem_type rb;
      if (w.opcode == OP_FIND) begin
         ans.root_index     = settle_root(w.first_element);
         ans.already_joined = 1'b0;
      end else begin
         ra = settle_root(w.first_element);
         rb = settle_root(w.second_element);
         ans.already_joined = (ra == rb);
         if (ra != rb && has_entry(ra) && has_entry(rb))
            links[ra] = rb;
         ans.root_index = rb;
      end
      return ans;
   endfunction

   task automatic queue_word(input logic op, input int a, input int b);
      req_type w;
      w.opcode         = op;
      w.first_element  = a[ELEM_W-1:0];
      w.second_element = b[ELEM_W-1:0];
      words_waiting.insert(words_waiting.size(), w);
   endtask

   // element close to base, clipped to the table
   function automatic int nudge(int base, int span);
      int v;
      v = base + $urandom_range(0, span);
      return (v > TOP_ELEM) ? TOP_ELEM : v;
   endfunction

   // driver: new word at the falling edge once the last one was taken
   always @(negedge clock) begin : driver
      logic    nxt_start;
      req_type nxt_word;
      nxt_start = start;
      nxt_word  = req_word;
      if (!reset && (!start || word_taken)) begin
         nxt_start = 1'b0;
         if (stretch_left == 0) begin
            stretch_left = $urandom_range(20, 60);
            gaps_on      = 1'($urandom_range(0, 1));
         end else begin
            stretch_left--;
         end
         if (gap_left > 0) begin
            gap_left--;
         end else if (gaps_on && words_waiting.size() > CALM_WORDS &&
                      $urandom_range(0, 3) == 0) begin
            gap_left = $urandom_range(0, 2);
         end else if (words_waiting.size() != 0) begin
            nxt_start = 1'b1;
            nxt_word  = words_waiting.pop_front();
         end
      end
      start    <= nxt_start;
      req_word <= nxt_word;
   end

   // monitor: sample both channels at the rising edge
   always @(posedge clock) begin : monitor
      logic    taken;
      rsp_type due;
      taken = !reset && start && !busy;
      word_taken <= taken;
      if (!reset && rsp_strobe) begin
         if (answers_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected response root=%0d joined=%0b",
                                    rsp_word.root_index, rsp_word.already_joined));
         end else begin
            due = answers_due.pop_front();
            if (rsp_word.root_index !== due.root_index)
               flag_mismatch($sformatf("root_index got %0d want %0d",
                                       rsp_word.root_index, due.root_index));
            if (rsp_word.already_joined !== due.already_joined)
               flag_mismatch($sformatf("already_joined got %0b want %0b",
                                       rsp_word.already_joined, due.already_joined));
         end
      end
      if (taken)
         answers_due.insert(answers_due.size(), predict_answer(req_word));
   end

   // watchdog: cycles with no word moving on either channel
   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      int total;
      int base;
      int len;
      int pick;
      for (int i = 0; i < TABLE_DEPTH; i++)
         links[i] = i[ELEM_W-1:0];

      // directed: extremes, self unite, repeat unite, a long chain
      queue_word(OP_FIND,  0, TOP_ELEM);
      queue_word(OP_FIND,  TOP_ELEM, 0);
      queue_word(OP_UNITE, 0, 0);
      queue_word(OP_UNITE, TOP_ELEM, TOP_ELEM);
      queue_word(OP_UNITE, 0, TOP_ELEM);
      queue_word(OP_UNITE, 0, TOP_ELEM);
      queue_word(OP_FIND,  0, 0);
      for (int j = 0; j < 12; j++)
         queue_word(OP_UNITE, 100 + j, 101 + j);
      queue_word(OP_FIND,  100, 341);
      queue_word(OP_FIND,  100, 682);
      queue_word(OP_UNITE, 112, 100);
      queue_word(OP_UNITE, 341, 682);
      queue_word(OP_FIND,  682, 341);

      // random: chains, local merges, full-range words
      total = words_waiting.size() + RANDOM_ITEMS;
      while (words_waiting.size() < total) begin
         pick = $urandom_range(0, 9);
         base = $urandom_range(0, TOP_ELEM);
         case (pick)
            0, 1: begin
               base = $urandom_range(0, TOP_ELEM - 13);
               len  = $urandom_range(3, 12);
               for (int j = 0; j < len; j++)
                  queue_word(OP_UNITE, base + j, base + j + 1);
               queue_word(OP_FIND, base, $urandom_range(0, TOP_ELEM));
            end
            2, 3, 4: queue_word(OP_UNITE, nudge(base, 31), nudge(base, 31));
            5:       queue_word(OP_UNITE, base, $urandom_range(0, TOP_ELEM));
            6, 7:    queue_word(OP_FIND, nudge(base, 31), $urandom_range(0, TOP_ELEM));
            8: begin
               case ($urandom_range(0, 2))
                  0: base = 0;
                  1: base = TOP_ELEM;
                  default: ;
               endcase
               queue_word(OP_UNITE, base, base);
            end
            default: queue_word(OP_FIND, base, $urandom_range(0, TOP_ELEM));
         endcase
      end

      // hold reset, then release it at a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (words_waiting.size() != 0 || start)
         @(posedge clock);
      while (answers_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/ufe_pkg.sv
hw/rtl/ufe_front.sv
hw/rtl/ufe_back.sv
hw/rtl/union_find_engine.sv
bench/tb_union_find_engine.sv
